// ----- rtl/mwsg_pkg.sv -----
// Shared types and constants of the multi-waveform sample generator.
// No dependencies; used by every module under rtl/.
package mwsg_pkg;

   // Parameter defaults
   localparam int INDEX_BITS_DEFAULT      = 16;
   localparam int SAMPLE_BITS_DEFAULT     = 16;
   localparam int SINE_TABLE_BITS_DEFAULT = 10;

   // Fixed field widths
   localparam int AMP_BITS      = 15;
   localparam int PHASE_BITS    = 32;
   localparam int POS_BITS      = 16;
   localparam int LENGTH_BITS   = 17;
   localparam int MAG_BITS      = 16;
   localparam int ENTRY_BITS    = 16;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_IDX_BITS  = 3;

   // Divider shape: 32-bit dividend, 8 restoring steps per stage
   localparam int DIVIDEND_BITS = 32;
   localparam int DIV_STEPS     = 8;

   // Sine table generation constants, Q30
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] Q30_ONE     = 64'd1 << 30;

   // Reset values
   localparam logic [AMP_BITS-1:0]    AMP_RESET    = AMP_BITS'(1);
   localparam logic [POS_BITS-1:0]    TRAIN_RESET  = POS_BITS'(1);
   localparam logic [LENGTH_BITS-1:0] LENGTH_RESET = LENGTH_BITS'(1024);

   typedef enum logic [2:0] {
      MODE_OFF,
      MODE_NEG_SINE,
      MODE_COSINE,
      MODE_IMPULSE,
      MODE_TRAIN,
      MODE_UNIFORM,
      MODE_TRIANGLE,
      MODE_RECTANGLE
   } mode_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_MODE,
      CSR_AMPLITUDE,
      CSR_PHASE_STEP,
      CSR_PHASE_OFFSET,
      CSR_CENTER,
      CSR_PULSE_WIDTH,
      CSR_TRAIN_INTERVAL,
      CSR_LENGTH
   } csr_index_type;

   // Per-request flags that travel down the pipeline
   typedef struct packed {
      logic oor;       // index at or beyond length
      logic last;      // index is length - 1
      logic imp_hit;   // index equals center
      logic zero_idx;  // index is zero
      logic tri_win;   // inside triangle support
      logic rect_win;  // inside rectangle support
   } ctl_type;

endpackage

// ----- rtl/mwsg_sine_rom.sv -----
// Quarter-wave sine table with registered read.
// Depends on mwsg_pkg; the table is built at elaboration.
module mwsg_sine_rom #(
   parameter int TABLE_BITS = mwsg_pkg::SINE_TABLE_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            enable,
   input  logic [TABLE_BITS:0]             address,
   output logic [mwsg_pkg::ENTRY_BITS-1:0] entry
);
   import mwsg_pkg::*;

   localparam int DEPTH = 2 ** TABLE_BITS + 1;

   typedef logic [ENTRY_BITS-1:0] table_type [DEPTH];

   // round(2^15 * sin(pi/2 * k / 2^TABLE_BITS)) via 8-term Horner series in Q30
   function automatic logic [ENTRY_BITS-1:0] quarter_entry(input int unsigned k);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      x  = (HALF_PI_Q30 * 64'(k)) >> TABLE_BITS;
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd272;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd210;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd156;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
      s  = (x * t) >> 30;
      return ENTRY_BITS'((s + 64'd16384) >> 15);
   endfunction

   function automatic table_type build_table();
      table_type tbl;
      for (int unsigned k = 0; k < DEPTH; k++) begin
         tbl[k] = quarter_entry(k);
      end
      return tbl;
   endfunction

   localparam table_type SINE_TABLE = build_table();

   logic [ENTRY_BITS-1:0] entry_ff;

   // Synchronous read, held while the pipeline stalls
   always_ff @(posedge clock) begin
      if (enable) begin
         entry_ff <= SINE_TABLE[address];
      end
   end

   assign entry = entry_ff;

endmodule

// ----- rtl/mwsg_div_pipe.sv -----
// Pipelined restoring divider: quotient and remainder, a few steps per stage.
// Depends on mwsg_pkg for default widths.
module mwsg_div_pipe #(
   parameter int DIVIDEND_BITS   = mwsg_pkg::DIVIDEND_BITS,
   parameter int DIVISOR_BITS    = mwsg_pkg::POS_BITS,
   parameter int STEPS_PER_STAGE = mwsg_pkg::DIV_STEPS
) (
   input  logic                     clock,
   input  logic                     enable,
   input  logic [DIVIDEND_BITS-1:0] dividend,
   input  logic [DIVISOR_BITS-1:0]  divisor,
   output logic [DIVIDEND_BITS-1:0] quotient,
   output logic [DIVISOR_BITS-1:0]  remainder
);
   import mwsg_pkg::*;

   localparam int STAGES = DIVIDEND_BITS / STEPS_PER_STAGE;

   // Bank 0 holds the operands; bank s holds the state after s stages.
   // nq shifts dividend bits out of the top and quotient bits in at the bottom.
   // The divisor is only needed by the stages that still run steps.
   logic [DIVIDEND_BITS-1:0] nq_ff  [STAGES+1];
   logic [DIVISOR_BITS-1:0]  rem_ff [STAGES+1];
   logic [DIVISOR_BITS-1:0]  den_ff [STAGES];
   logic [DIVIDEND_BITS-1:0] nq_in  [STAGES];
   logic [DIVISOR_BITS-1:0]  rem_in [STAGES];

   // Restoring steps of every stage
   always_comb begin
      logic [DIVISOR_BITS:0]    trial;
      logic [DIVISOR_BITS-1:0]  r;
      logic [DIVIDEND_BITS-1:0] nq;
      for (int s = 0; s < STAGES; s++) begin
         r  = rem_ff[s];
         nq = nq_ff[s];
         for (int j = 0; j < STEPS_PER_STAGE; j++) begin
            trial = {r, nq[DIVIDEND_BITS-1]};
            nq    = {nq[DIVIDEND_BITS-2:0], 1'b0};
            if (trial >= {1'b0, den_ff[s]}) begin
               trial = trial - {1'b0, den_ff[s]};
               nq[0] = 1'b1;
            end
            r = trial[DIVISOR_BITS-1:0];
         end
         nq_in[s]  = nq;
         rem_in[s] = r;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         nq_ff[0]  <= dividend;
         rem_ff[0] <= '0;
         den_ff[0] <= divisor;
         for (int s = 0; s < STAGES; s++) begin
            nq_ff[s+1]  <= nq_in[s];
            rem_ff[s+1] <= rem_in[s];
         end
         for (int s = 1; s < STAGES; s++) begin
            den_ff[s] <= den_ff[s-1];
         end
      end
   end

   assign quotient  = nq_ff[STAGES];
   assign remainder = rem_ff[STAGES];

endmodule

// ----- rtl/multi_waveform_sample_generator_unit.sv -----
// Top level of the multi-waveform sample generator: CSRs, pipeline, output register.
// Depends on mwsg_pkg, mwsg_sine_rom and mwsg_div_pipe.
//
// Usage: write the CSRs (mode, amplitude, phase_step, phase_offset, center,
// pulse_width, train_interval, length) through csr_we/csr_index/csr_wdata
// while no request is in flight. Then send sample indices on the req_
// valid/ready channel; each request gives exactly one response on the rsp_
// channel carrying the sample, a last flag and an out-of-range flag.
// The pipeline takes one request per cycle unless the receiver stalls; its
// depth is set by the 32-step divider (four stages of eight steps) used for
// impulse-train remainders and triangle ratios, with the sine path (phase
// multiply, table read, amplitude scale) running beside it.
// When the receiver stalls the response register holds and the whole pipeline
// freezes, so req_ready drops while a response waits and nothing is lost.
// Reset (synchronous, active high) empties the pipeline and loads the CSR
// defaults: mode off, amplitude 1, train_interval 1, length 1024, rest zero.
module multi_waveform_sample_generator_unit #(
   parameter int INDEX_BITS      = mwsg_pkg::INDEX_BITS_DEFAULT,
   parameter int SAMPLE_BITS     = mwsg_pkg::SAMPLE_BITS_DEFAULT,
   parameter int SINE_TABLE_BITS = mwsg_pkg::SINE_TABLE_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // configuration
   input  logic                               csr_we,
   input  logic [mwsg_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [mwsg_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   // requests
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [INDEX_BITS-1:0]              req_sample_index,
   // responses
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]      rsp_sample,
   output logic                               rsp_last,
   output logic                               rsp_out_of_range
);
   import mwsg_pkg::*;

   localparam int SUM_BITS = ((INDEX_BITS > LENGTH_BITS) ? INDEX_BITS : LENGTH_BITS) + 1;
   localparam logic [31:0] MAX_MAG = 32'((2 ** (SAMPLE_BITS - 1)) - 1);
   localparam logic [SINE_TABLE_BITS:0] QUARTER = (SINE_TABLE_BITS + 1)'(2 ** SINE_TABLE_BITS);
   localparam int PIPE_DEPTH = 6;

   // ---------------------------------------------------------------- CSRs
   mode_type               mode_ff;
   logic [AMP_BITS-1:0]    amplitude_ff;
   logic [PHASE_BITS-1:0]  phase_step_ff;
   logic [PHASE_BITS-1:0]  phase_offset_ff;
   logic [POS_BITS-1:0]    center_ff;
   logic [POS_BITS-1:0]    pulse_width_ff;
   logic [POS_BITS-1:0]    train_interval_ff;
   logic [LENGTH_BITS-1:0] length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff           <= MODE_OFF;
         amplitude_ff      <= AMP_RESET;
         phase_step_ff     <= '0;
         phase_offset_ff   <= '0;
         center_ff         <= '0;
         pulse_width_ff    <= '0;
         train_interval_ff <= TRAIN_RESET;
         length_ff         <= LENGTH_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_MODE:           mode_ff           <= mode_type'(csr_wdata[2:0]);
            CSR_AMPLITUDE:      amplitude_ff      <= csr_wdata[AMP_BITS-1:0];
            CSR_PHASE_STEP:     phase_step_ff     <= csr_wdata[PHASE_BITS-1:0];
            CSR_PHASE_OFFSET:   phase_offset_ff   <= csr_wdata[PHASE_BITS-1:0];
            CSR_CENTER:         center_ff         <= csr_wdata[POS_BITS-1:0];
            CSR_PULSE_WIDTH:    pulse_width_ff    <= csr_wdata[POS_BITS-1:0];
            CSR_TRAIN_INTERVAL: train_interval_ff <= csr_wdata[POS_BITS-1:0];
            CSR_LENGTH:         length_ff         <= csr_wdata[LENGTH_BITS-1:0];
            default: ;
         endcase
      end
   end

   // half width, truncated
   logic [AMP_BITS-1:0] half;
   assign half = pulse_width_ff[POS_BITS-1:1];

   // ------------------------------------------------------ pipeline control
   logic                  advance;
   logic [PIPE_DEPTH-1:0] valid_ff;
   logic                  rsp_valid_ff;

   // whole pipe moves unless a response is waiting to be taken
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff     <= {valid_ff[PIPE_DEPTH-2:0], req_valid};
         rsp_valid_ff <= valid_ff[PIPE_DEPTH-1];
      end
   end

   // ------------------------------------- stage 1: compares and phase product
   logic [SUM_BITS-1:0]   x_s;
   logic [SUM_BITS-1:0]   c_s;
   logic [SUM_BITS-1:0]   h_s;
   logic [SUM_BITS-1:0]   xh;
   logic [SUM_BITS-1:0]   ch;
   logic                  x_lt_c;
   ctl_type               ctl1_in;
   logic [POS_BITS-1:0]   num1_in;
   logic [PHASE_BITS-1:0] prod1_in;

   always_comb begin
      x_s    = SUM_BITS'(req_sample_index);
      c_s    = SUM_BITS'(center_ff);
      h_s    = SUM_BITS'(half);
      xh     = x_s + h_s;
      ch     = c_s + h_s;
      x_lt_c = x_s < c_s;

      ctl1_in.oor      = x_s >= SUM_BITS'(length_ff);
      ctl1_in.last     = (x_s + SUM_BITS'(1)) == SUM_BITS'(length_ff);
      ctl1_in.imp_hit  = x_s == c_s;
      ctl1_in.zero_idx = req_sample_index == '0;
      ctl1_in.tri_win  = (x_lt_c && (xh >= c_s)) || (!x_lt_c && (x_s < ch));
      ctl1_in.rect_win = (xh >= c_s) && (x_s < ch);

      // rising edge: x + half - center; falling edge: center + half - x
      num1_in  = x_lt_c ? POS_BITS'(xh - c_s) : POS_BITS'(ch - x_s);
      prod1_in = phase_step_ff * 32'(req_sample_index);
   end

   logic [INDEX_BITS-1:0] x1_ff;
   logic [POS_BITS-1:0]   num1_ff;
   logic [PHASE_BITS-1:0] prod1_ff;
   ctl_type               ctl_ff [PIPE_DEPTH];

   always_ff @(posedge clock) begin
      if (advance) begin
         x1_ff     <= req_sample_index;
         num1_ff   <= num1_in;
         prod1_ff  <= prod1_in;
         ctl_ff[0] <= ctl1_in;
         for (int s = 1; s < PIPE_DEPTH; s++) begin
            ctl_ff[s] <= ctl_ff[s-1];
         end
      end
   end

   // --------------------------------- stage 2: phase add, divider operands
   logic [DIVIDEND_BITS-1:0] dividend2_in;
   logic [POS_BITS-1:0]      divisor2_in;
   logic [PHASE_BITS-1:0]    phase2_ff;

   always_comb begin
      if (mode_ff == MODE_TRIANGLE) begin
         dividend2_in = 32'(amplitude_ff) * 32'(num1_ff) + 32'(half[AMP_BITS-1:1]);
         divisor2_in  = POS_BITS'(half);
      end else begin
         dividend2_in = DIVIDEND_BITS'(x1_ff);
         divisor2_in  = train_interval_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         phase2_ff <= phase_offset_ff + prod1_ff;
      end
   end

   // divider: operands registered at stage 2, results at stage 6
   logic [DIVIDEND_BITS-1:0] quot6;
   logic [POS_BITS-1:0]      rem6;

   mwsg_div_pipe #(
      .DIVIDEND_BITS   (DIVIDEND_BITS),
      .DIVISOR_BITS    (POS_BITS),
      .STEPS_PER_STAGE (DIV_STEPS)
   ) u_div (
      .clock     (clock),
      .enable    (advance),
      .dividend  (dividend2_in),
      .divisor   (divisor2_in),
      .quotient  (quot6),
      .remainder (rem6)
   );

   // --------------------------------------- stage 3: quadrant and table read
   logic [1:0]                 quad3;
   logic [SINE_TABLE_BITS-1:0] frac3;
   logic [SINE_TABLE_BITS:0]   addr3;
   logic                       sneg3_in;
   logic [ENTRY_BITS-1:0]      rom3;

   always_comb begin
      // cosine is the sine a quarter turn ahead
      quad3    = phase2_ff[PHASE_BITS-1 -: 2] + {1'b0, mode_ff == MODE_COSINE};
      frac3    = phase2_ff[PHASE_BITS-3 -: SINE_TABLE_BITS];
      addr3    = quad3[0] ? (QUARTER - {1'b0, frac3}) : {1'b0, frac3};
      sneg3_in = quad3[1] ^ (mode_ff == MODE_NEG_SINE);
   end

   mwsg_sine_rom #(
      .TABLE_BITS (SINE_TABLE_BITS)
   ) u_rom (
      .clock   (clock),
      .enable  (advance),
      .address (addr3),
      .entry   (rom3)
   );

   // --------------------------------------- stages 3..6: sine scale and align
   logic                         sneg3_ff;
   logic                         sneg4_ff;
   logic                         sneg5_ff;
   logic                         sneg6_ff;
   logic [AMP_BITS+ENTRY_BITS-1:0] sprod4_ff;
   logic [MAG_BITS-1:0]          smag5_ff;
   logic [MAG_BITS-1:0]          smag6_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         sneg3_ff  <= sneg3_in;
         sneg4_ff  <= sneg3_ff;
         sneg5_ff  <= sneg4_ff;
         sneg6_ff  <= sneg5_ff;
         sprod4_ff <= (AMP_BITS + ENTRY_BITS)'(amplitude_ff) * (AMP_BITS + ENTRY_BITS)'(rom3);
         smag5_ff  <= MAG_BITS'((32'(sprod4_ff) + 32'd16384) >> 15);
         smag6_ff  <= smag5_ff;
      end
   end

   // ---------------------------------------- stage 7: select, clamp, output
   ctl_type                  ctl6;
   logic [MAG_BITS-1:0]      mag;
   logic                     neg;
   logic [31:0]              mag_wide;
   logic [SAMPLE_BITS-1:0]   sample_in;

   assign ctl6 = ctl_ff[PIPE_DEPTH-1];

   always_comb begin
      mag = '0;
      neg = 1'b0;
      case (mode_ff)
         MODE_NEG_SINE, MODE_COSINE: begin
            mag = smag6_ff;
            neg = sneg6_ff;
         end
         MODE_IMPULSE: begin
            if (ctl6.imp_hit) mag = MAG_BITS'(amplitude_ff);
         end
         MODE_TRAIN: begin
            // zero spacing keeps only the first sample
            if ((train_interval_ff == '0) ? ctl6.zero_idx : (rem6 == '0)) begin
               mag = MAG_BITS'(amplitude_ff);
            end
         end
         MODE_UNIFORM: begin
            mag = MAG_BITS'(amplitude_ff);
         end
         MODE_TRIANGLE: begin
            if (ctl6.tri_win) mag = quot6[MAG_BITS-1:0];
         end
         MODE_RECTANGLE: begin
            if (ctl6.rect_win) mag = MAG_BITS'(amplitude_ff);
         end
         default: ;
      endcase
      if (ctl6.oor) mag = '0;
      mag_wide = 32'(mag);
      if (mag_wide > MAX_MAG) mag_wide = MAX_MAG;
      if (mag_wide == 32'd0) neg = 1'b0;
      sample_in = SAMPLE_BITS'(neg ? (32'd0 - mag_wide) : mag_wide);
   end

   logic [SAMPLE_BITS-1:0] rsp_sample_ff;
   logic                   rsp_last_ff;
   logic                   rsp_oor_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_sample_ff <= sample_in;
         rsp_last_ff   <= ctl6.last;
         rsp_oor_ff    <= ctl6.oor;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample       = signed'(rsp_sample_ff);
   assign rsp_last         = rsp_last_ff;
   assign rsp_out_of_range = rsp_oor_ff;

endmodule

// ----- tb/tb_multi_waveform_sample_generator_unit.sv -----
// Self-checking testbench for multi_waveform_sample_generator_unit: a directed table, then
// random segments under four idle profiles, checked against typed results or an in-bench predictor.
// Depends on mwsg_pkg and the block's RTL.
module tb_multi_waveform_sample_generator_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import mwsg_pkg::*;

   localparam int SETTLE_CYCLES = 10;
   localparam int STALL_LIMIT   = 2000;
   localparam int SEGMENTS      = 16;
   localparam int SEGMENT_ITEMS = 25;
   localparam int HOLD_CYCLES   = 80;
   localparam int MAX_GAP       = 20;
   localparam int REPORT_LIMIT  = 10;
   localparam int TABLE_BITS    = SINE_TABLE_BITS_DEFAULT;
   localparam int DIRECTED_ROWS = 53;
   localparam int unsigned MAX_MAG = 32767;
   localparam logic [63:0] QUARTER_TURN_Q30 = 64'd1686629713;
   localparam logic [63:0] UNIT_Q30         = 64'd1 << 30;

   typedef struct packed {
      logic signed [15:0] sample;
      logic               last;
      logic               oor;
   } sample_result_type;

   typedef struct {
      mode_type    mode;
      logic [14:0] amplitude;
      logic [31:0] phase_step;
      logic [31:0] phase_offset;
      logic [15:0] center;
      logic [15:0] pulse_width;
      logic [15:0] train_interval;
      logic [16:0] length;
   } waveform_cfg_type;

   typedef enum logic {ROW_WRITE, ROW_SEND} row_kind_type;

   // one table row: a register write, or a request with an optional hand-typed result
   typedef struct packed {
      row_kind_type      kind;
      csr_index_type     csr;
      logic [31:0]       value;
      logic              typed;
      sample_result_type result;
   } plan_row_type;

   localparam sample_result_type NO_RESULT = '{16'sd0, 1'b0, 1'b0};

   // DUT signals; all inputs driven to known values from time zero
   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_we = 1'b0;
   csr_index_type       csr_index = CSR_MODE;
   logic [31:0]         csr_wdata = '0;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [15:0]         req_sample_index = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic signed [15:0]  rsp_sample;
   logic                rsp_last;
   logic                rsp_out_of_range;

   waveform_cfg_type  cfg;
   sample_result_type pending_samples[$];
   sample_result_type oldest;
   int mismatches     = 0;
   int requests_sent  = 0;
   int responses_seen = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_tokens    = 0;
   int hold_seen      = 0;
   int hold_left      = 0;
   int idle_cycles    = 0;

   // directed stimulus; typed results only where the value is obvious
   plan_row_type directed_plan [DIRECTED_ROWS] = '{
      // reset state: mode off, length 1024
      '{ROW_SEND,  CSR_MODE, 32'd0,     1'b1, '{16'sd0, 1'b0, 1'b0}},
      '{ROW_SEND,  CSR_MODE, 32'd1023,  1'b1, '{16'sd0, 1'b1, 1'b0}},
      '{ROW_SEND,  CSR_MODE, 32'd1024,  1'b1, '{16'sd0, 1'b0, 1'b1}},
      '{ROW_SEND,  CSR_MODE, 32'd65535, 1'b1, '{16'sd0, 1'b0, 1'b1}},
      // uniform level at full scale over the longest record
      '{ROW_WRITE, CSR_MODE,      32'(MODE_UNIFORM), 1'b0, NO_RESULT},
      '{ROW_WRITE, CSR_AMPLITUDE, 32'd32767,         1'b0, NO_RESULT},
      '{ROW_WRITE, CSR_LENGTH,    32'd65536,         1'b0, NO_RESULT},
      '{ROW_SEND,  CSR_MODE, 32'd0,     1'b1, '{16'sd32767, 1'b0, 1'b0}},
      '{ROW_SEND,  CSR_MODE, 32'd65535, 1'b1, '{16'sd32767, 1'b1, 1'b0}},
      '{ROW_WRITE, CSR_AMPLITUDE, 32'd0,             1'b0, NO_RESULT},
      '{ROW_SEND,  CSR_MODE, 32'd5,     1'b1, '{16'sd0, 1'b0, 1'b0}},
      // zero length: everything out of range
      '{ROW_WRITE, CSR_AMPLITUDE, 32'd32767,         1'b0, NO_RESULT},
      '{ROW_WRITE, CSR_LENGTH,    32'd0,             1'b0, NO_RESULT},
      '{ROW_SEND,  CSR_MODE, 32'd0,     1'b1, '{16'sd0, 1'b0, 1'b1}},
      // negated sine, 256 samples per turn
      '{ROW_WRITE, CSR_LENGTH,       32'd100,           1'b0, NO_RESULT},
      '{ROW_WRITE, CSR_MODE,         32'(MODE_NEG_SINE), 1'b0, NO_RESULT},
      '{ROW_WRITE, CSR_PHASE_STEP,   32'h0100_0000,     1'b0, NO_RESULT},
      '{ROW_WRITE, CSR_PHASE_OFFSET, 32'd0,             1'b0, NO_RESULT},
      '{ROW_SEND,  CSR_MODE, 32'd0,     1'b1, '{16'sd0, 1'b0, 1'b0}},
      '{ROW_SEND,  CSR_MODE, 32'd16,    1'b0, NO_RESULT},
      '{ROW_SEND,  CSR_MODE, 32'd48,    1'b0, NO_RESULT},
      // cosine, then with step and offset at their maximum
      '{ROW_WRITE, CSR_MODE,         32'(MODE_COSINE),  1'b0, NO_RESULT},
      '{ROW_SEND,  CSR_MODE, 32'd0,     1'b0, NO_RESULT},
      '{ROW_SEND,  CSR_MODE, 32'd37,    1'b0, NO_RESULT},
      '{ROW_WRITE, CSR_PHASE_STEP,   32'hFFFF_FFFF,     1'b0, NO_RESULT},
      '{ROW_WRITE, CSR_PHASE_OFFSET, 32'hFFFF_FFFF,     1'b0, NO_RESULT},
      '{ROW_SEND,  CSR_MODE, 32'd99,    1'b0, NO_RESULT},
      // impulse on the last sample, then just past the record
      '{ROW_WRITE, CSR_MODE,   32'(MODE_IMPULSE), 1'b0, NO_RESULT},
      '{ROW_WRITE, CSR_CENTER, 32'd99,            1'b0, NO_RESULT},
      '{ROW_SEND,  CSR_MODE, 32'd99,    1'b1, '{16'sd32767, 1'b1, 1'b0}},
      '{ROW_SEND,  CSR_MODE, 32'd98,    1'b1, '{16'sd0, 1'b0, 1'b0}},
      '{ROW_WRITE, CSR_CENTER, 32'd100,           1'b0, NO_RESULT},
      '{ROW_SEND,  CSR_MODE, 32'd99,    1'b1, '{16'sd0, 1'b1, 1'b0}},
      // impulse train: zero interval hits only index 0
      '{ROW_WRITE, CSR_MODE,           32'(MODE_TRAIN), 1'b0, NO_RESULT},
      '{ROW_WRITE, CSR_TRAIN_INTERVAL, 32'd0,           1'b0, NO_RESULT},
      '{ROW_SEND,  CSR_MODE, 32'd0,     1'b1, '{16'sd32767, 1'b0, 1'b0}},
      '{ROW_SEND,  CSR_MODE, 32'd10,    1'b1, '{16'sd0, 1'b0, 1'b0}},
      '{ROW_WRITE, CSR_TRAIN_INTERVAL, 32'd7,           1'b0, NO_RESULT},
      '{ROW_SEND,  CSR_MODE, 32'd14,    1'b1, '{16'sd32767, 1'b0, 1'b0}},
      // triangle clipped at the left edge, then at the right edge
      '{ROW_WRITE, CSR_MODE,        32'(MODE_TRIANGLE), 1'b0, NO_RESULT},
      '{ROW_WRITE, CSR_CENTER,      32'd0,              1'b0, NO_RESULT},
      '{ROW_WRITE, CSR_PULSE_WIDTH, 32'd10,             1'b0, NO_RESULT},
      '{ROW_SEND,  CSR_MODE, 32'd2,     1'b0, NO_RESULT},
      '{ROW_WRITE, CSR_CENTER,      32'd98,             1'b0, NO_RESULT},
      '{ROW_SEND,  CSR_MODE, 32'd99,    1'b0, NO_RESULT},
      // half width zero kills the triangle
      '{ROW_WRITE, CSR_PULSE_WIDTH, 32'd1,              1'b0, NO_RESULT},
      '{ROW_SEND,  CSR_MODE, 32'd98,    1'b1, '{16'sd0, 1'b0, 1'b0}},
      // rectangle at maximum width and center, then half width zero
      '{ROW_WRITE, CSR_MODE,        32'(MODE_RECTANGLE), 1'b0, NO_RESULT},
      '{ROW_WRITE, CSR_PULSE_WIDTH, 32'd65535,           1'b0, NO_RESULT},
      '{ROW_WRITE, CSR_CENTER,      32'd65535,           1'b0, NO_RESULT},
      '{ROW_SEND,  CSR_MODE, 32'd50,    1'b0, NO_RESULT},
      '{ROW_WRITE, CSR_PULSE_WIDTH, 32'd1,               1'b0, NO_RESULT},
      '{ROW_SEND,  CSR_MODE, 32'd50,    1'b1, '{16'sd0, 1'b0, 1'b0}}
   };

   multi_waveform_sample_generator_unit dut (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample_index (req_sample_index),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sample       (rsp_sample),
      .rsp_last         (rsp_last),
      .rsp_out_of_range (rsp_out_of_range)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // quarter-wave table entry k: Horner sine series in Q30, rounded to Q15
   function automatic logic [15:0] quarter_wave_entry(int unsigned k);
      logic [63:0] angle;
      logic [63:0] angle_sq;
      logic [63:0] acc;
      logic [63:0] divisor;
      int          n;
      angle    = (QUARTER_TURN_Q30 * 64'(k)) >> TABLE_BITS;
      angle_sq = (angle * angle) >> 30;
      acc      = UNIT_Q30;
      for (n = 8; n >= 1; n--) begin
         divisor = 64'(2 * n) * 64'(2 * n + 1);
         acc     = UNIT_Q30 - ((angle_sq * acc) >> 30) / divisor;
      end
      return 16'((((angle * acc) >> 30) + 64'd16384) >> 15);
   endfunction

   // scaled sine magnitude for a phase; neg set in the lower half turn
   function automatic int unsigned sine_magnitude(logic [31:0] phase, output logic neg);
      logic [TABLE_BITS-1:0] frac;
      int unsigned           k;
      frac = phase[29:30-TABLE_BITS];
      k    = phase[30] ? (1 << TABLE_BITS) - frac : frac;
      neg  = phase[31];
      return int'((64'(cfg.amplitude) * quarter_wave_entry(k) + 64'd16384) >> 15);
   endfunction

   function automatic int unsigned ramp_level(int unsigned num, int unsigned half);
      return int'((64'(cfg.amplitude) * num + 64'(half / 2)) / half);
   endfunction

   // expected response for one sample index under the current register values
   function automatic sample_result_type predict_sample(logic [15:0] index);
      int unsigned       x;
      int unsigned       half;
      int unsigned       mag;
      logic              neg;
      logic [31:0]       phase;
      sample_result_type r;
      x     = index;
      half  = cfg.pulse_width / 2;
      mag   = 0;
      neg   = 1'b0;
      r.oor  = x >= cfg.length;
      r.last = (x + 1) == cfg.length;
      if (!r.oor) begin
         phase = cfg.phase_offset + cfg.phase_step * x;
         case (cfg.mode)
            MODE_NEG_SINE: begin
               mag = sine_magnitude(phase, neg);
               neg = !neg;
            end
            MODE_COSINE: mag = sine_magnitude(phase + 32'h4000_0000, neg);
            MODE_IMPULSE: if (x == cfg.center) mag = cfg.amplitude;
            MODE_TRAIN: begin
               if (cfg.train_interval == 0 ? x == 0 : x % cfg.train_interval == 0)
                  mag = cfg.amplitude;
            end
            MODE_UNIFORM: mag = cfg.amplitude;
            MODE_TRIANGLE: begin
               if (half != 0) begin
                  if (x < cfg.center && x + half >= cfg.center)
                     mag = ramp_level(x + half - cfg.center, half);
                  else if (x >= cfg.center && x < cfg.center + half)
                     mag = ramp_level(half - (x - cfg.center), half);
               end
            end
            MODE_RECTANGLE: begin
               if (x + half >= cfg.center && x < cfg.center + half) mag = cfg.amplitude;
            end
            default: mag = 0;
         endcase
      end
      if (mag > MAX_MAG) mag = MAX_MAG;
      if (mag == 0) neg = 1'b0;
      r.sample = neg ? 16'(0 - mag) : 16'(mag);
      return r;
   endfunction

   // random index: mostly inside the record, some anywhere, some at the edges of features
   function automatic logic [15:0] pick_index();
      int unsigned hi;
      int unsigned r;
      hi = cfg.length + 3;
      if (hi > 65535) hi = 65535;
      r = $urandom_range(99);
      if (r < 75) return 16'($urandom_range(0, hi));
      if (r < 85) return 16'($urandom());
      case ($urandom_range(3))
         0: return 16'(cfg.length - 1 + $urandom_range(0, 2));
         1: return 16'(cfg.center - 1 + $urandom_range(0, 2));
         2: return 16'(cfg.center - cfg.pulse_width / 2 + $urandom_range(0, 2));
         default: return 16'(cfg.center + cfg.pulse_width / 2 - 1 + $urandom_range(0, 2));
      endcase
   endfunction

   // one register write; the caller drops csr_we after the last of a group
   task automatic csr_write(csr_index_type idx, logic [31:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_MODE:           cfg.mode           = mode_type'(value[2:0]);
         CSR_AMPLITUDE:      cfg.amplitude      = value[14:0];
         CSR_PHASE_STEP:     cfg.phase_step     = value;
         CSR_PHASE_OFFSET:   cfg.phase_offset   = value;
         CSR_CENTER:         cfg.center         = value[15:0];
         CSR_PULSE_WIDTH:    cfg.pulse_width    = value[15:0];
         CSR_TRAIN_INTERVAL: cfg.train_interval = value[15:0];
         default:            cfg.length         = value[16:0];
      endcase
      @(posedge clock);
   endtask

   // stop sending and wait until every outstanding request has answered
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // offer one request, hold it until taken, then maybe go idle for a while
   task automatic send_index(logic [15:0] index, logic typed, sample_result_type typed_result);
      int gap;
      req_valid        <= 1'b1;
      req_sample_index <= index;
      do @(posedge clock); while (req_ready !== 1'b1);
      pending_samples.push_back(typed ? typed_result : predict_sample(index));
      requests_sent++;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // fresh random register set for one segment, biased toward small records
   task automatic program_segment(mode_type m);
      logic [16:0] len;
      int unsigned span;
      int unsigned r;
      r = $urandom_range(99);
      if (r < 10)      len = 17'd65536;
      else if (r < 13) len = 17'd0;
      else             len = 17'($urandom_range(1, 300));
      span = (len == 0) ? 16 : len + 8;
      if (span > 65535) span = 65535;
      csr_write(CSR_MODE, 32'(m));
      csr_write(CSR_LENGTH, 32'(len));
      r = $urandom_range(99);
      csr_write(CSR_AMPLITUDE, r < 10 ? 32'd32767 : r < 15 ? 32'd0 : $urandom_range(0, 32767));
      csr_write(CSR_PHASE_STEP,
                $urandom_range(1) ? $urandom() : $urandom_range(0, 32'h0400_0000));
      csr_write(CSR_PHASE_OFFSET, $urandom());
      csr_write(CSR_CENTER,
                $urandom_range(99) < 80 ? $urandom_range(0, span) : $urandom_range(0, 65535));
      csr_write(CSR_PULSE_WIDTH,
                $urandom_range(99) < 80 ? $urandom_range(0, 80) : $urandom_range(0, 65535));
      r = $urandom_range(99);
      csr_write(CSR_TRAIN_INTERVAL,
                r < 10 ? 32'd0 : r < 15 ? $urandom_range(0, 65535) : $urandom_range(1, 24));
   endtask

   // receiver: random stalls, plus a long hold whenever one is requested
   always @(posedge clock) begin
      if (hold_tokens != hold_seen) begin
         hold_seen <= hold_tokens;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // response checker: compare against the oldest outstanding expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         responses_seen++;
         if (pending_samples.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected response: sample %0d last %0b oor %0b",
                        rsp_sample, rsp_last, rsp_out_of_range);
         end else begin
            oldest = pending_samples.pop_front();
            if (rsp_sample !== oldest.sample || rsp_last !== oldest.last ||
                rsp_out_of_range !== oldest.oor) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("mismatch at response %0d: expected %0d/%0b/%0b got %0d/%0b/%0b",
                           responses_seen, oldest.sample, oldest.last, oldest.oor,
                           rsp_sample, rsp_last, rsp_out_of_range);
            end
         end
      end
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d responses outstanding",
                  STALL_LIMIT, pending_samples.size());
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      cfg = '{MODE_OFF, AMP_RESET, 32'd0, 32'd0, 16'd0, 16'd0, TRAIN_RESET, LENGTH_RESET};
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (directed_plan[i]) begin
         if (directed_plan[i].kind == ROW_WRITE) begin
            if (i == 0 || directed_plan[i-1].kind != ROW_WRITE) settle();
            csr_write(directed_plan[i].csr, directed_plan[i].value);
         end else begin
            if (i > 0 && directed_plan[i-1].kind == ROW_WRITE) csr_we <= 1'b0;
            send_index(directed_plan[i].value[15:0], directed_plan[i].typed,
                       directed_plan[i].result);
         end
      end

      // random segments: every mode twice, idle profile changes every four segments
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         case (seg / 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
            default: begin send_idle_pct = 8; recv_stall_pct = 8; end
         endcase
         settle();
         program_segment(mode_type'(seg % 8));
         csr_we <= 1'b0;
         // long receiver hold while requests keep coming, to back up the pipeline
         if (seg == 1) hold_tokens <= hold_tokens + 1;
         repeat (SEGMENT_ITEMS) send_index(pick_index(), 1'b0, NO_RESULT);
      end

      settle();
      $display("summary: %0d requests sent, %0d responses checked, %0d mismatches",
               requests_sent, responses_seen, mismatches);
      $display("summary: directed edge cases, then all eight modes under four idle profiles");
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
